// ===== rtl/core/bba_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Block bitmap allocator package
// Shared types, operation and status codes for the allocator controller and
// its datapath.
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 11;
    localparam int BLK_W     = 10;
    localparam int SHIFT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = 32;

    // Operation codes
    localparam logic [1:0] OP_ALLOCATE = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_INIT     = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [ADDR_W-1:0]  RST_BASE  = 32'd0;
    localparam logic [SHIFT_W-1:0] RST_SHIFT = 3'd1;
    localparam logic [CNT_W-1:0]   RST_COUNT = 11'd1024;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] free_sector_address;
    } t_alloc_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [BLK_W-1:0]  block_number;
        logic [ADDR_W-1:0] sector_address;
        logic [CNT_W-1:0]  free_count;
    } t_alloc_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_FREE_CALC,
        S_FREE_READ,
        S_COMMIT
    } t_ctrl_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan_run;
        logic free_calc;
        logic free_read;
        logic commit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic found;
        logic exhausted;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences one operation at a time through scan, free and commit phases.
// ---------------------------------------------------------------------------
module bba_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_op,
    input  wire bba_pkg::t_dp_stat i_stat,
    output logic                   o_in_ready,
    output bba_pkg::t_dp_cmd       o_cmd
);

    bba_pkg::t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bba_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_op)
                        bba_pkg::OP_ALLOCATE: n_state = bba_pkg::S_ALLOC_SCAN;
                        bba_pkg::OP_FREE:     n_state = bba_pkg::S_FREE_CALC;
                        default:              n_state = bba_pkg::S_COMMIT;
                    endcase
                end
            end
            bba_pkg::S_ALLOC_SCAN: begin
                o_cmd.scan_run = !i_stat.cnt_zero;
                if (i_stat.cnt_zero || i_stat.found || i_stat.exhausted) begin
                    n_state = bba_pkg::S_COMMIT;
                end
            end
            bba_pkg::S_FREE_CALC: begin
                o_cmd.free_calc = 1'b1;
                n_state         = bba_pkg::S_FREE_READ;
            end
            bba_pkg::S_FREE_READ: begin
                o_cmd.free_read = 1'b1;
                n_state         = bba_pkg::S_COMMIT;
            end
            bba_pkg::S_COMMIT: begin
                // The result is only produced once the output register can take it.
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/bba_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Block bitmap allocator datapath
// Bitmap memory, free-block counter, configuration registers, address
// arithmetic and the result register.
// ---------------------------------------------------------------------------
module bba_dpath #(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire bba_pkg::t_dp_cmd                 i_cmd,
    output bba_pkg::t_dp_stat                     o_stat,
    input  wire bba_pkg::t_alloc_req              i_req,
    input  wire logic                             i_cfg_we,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bba_pkg::ADDR_W-1:0]       i_cfg_data,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output bba_pkg::t_alloc_rsp                   o_out_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int ROW_W = (IDX_W > 5) ? IDX_W - 5 : 1;
    localparam int ROWS  = 2 ** ROW_W;
    localparam int SC_W  = ROW_W + 1;
    localparam int CMP_W = (SC_W > 7) ? SC_W : 7;
    localparam int POS_W = ROW_W + 5;
    localparam int RW    = ((POS_W > bba_pkg::CNT_W) ? POS_W : bba_pkg::CNT_W) + 1;
    localparam logic [31:0] MAXB = 32'(MAX_BLOCKS);

    // Configuration
    logic [bba_pkg::ADDR_W-1:0]  r_base;
    logic [bba_pkg::SHIFT_W-1:0] r_shift;
    logic [bba_pkg::CNT_W-1:0]   r_bc;

    // Captured request
    logic [1:0]                  r_op;
    logic [bba_pkg::ADDR_W-1:0]  r_addr;

    // Bitmap storage
    logic [bba_pkg::WORD_W-1:0]  r_mem [ROWS];
    logic [ROWS-1:0]             r_row_vld;
    logic [bba_pkg::WORD_W-1:0]  r_rd_word;
    logic                        r_rd_vld;

    // Scan state
    logic [SC_W-1:0]             r_scan_row;
    logic [ROW_W-1:0]            r_chk_row;
    logic                        r_chk_vld;
    logic                        r_hit;
    logic [POS_W-1:0]            r_blk;
    logic [ROW_W-1:0]            r_wr_row;
    logic [bba_pkg::WORD_W-1:0]  r_wr_word;

    // Free state
    logic [bba_pkg::ADDR_W-1:0]  r_idx;
    logic                        r_below;
    logic                        r_range;

    logic [bba_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_out_vld;
    bba_pkg::t_alloc_rsp         r_out, n_out;

    logic [bba_pkg::CNT_W-1:0]   n_eff;
    logic [11:0]                 nw_sum;
    logic [6:0]                  nwords;
    logic                        scan_more;
    logic                        rd_en;
    logic [ROW_W-1:0]            rd_row;
    logic [bba_pkg::WORD_W-1:0]  chk_word;
    logic [RW-1:0]               pos_ext, n_ext, remain;
    logic [bba_pkg::WORD_W-1:0]  range_mask;
    logic [bba_pkg::WORD_W-1:0]  free_bits;
    logic [4:0]                  hit_bit;
    logic                        found;
    logic                        wr_en;
    logic [ROW_W-1:0]            wr_row;
    logic [bba_pkg::WORD_W-1:0]  wr_word;
    logic                        vld_clear;
    logic [bba_pkg::WORD_W-1:0]  free_word;
    logic [POS_W+9:0]            blk_wide;
    logic                        out_free;

    // Blocks in use: block_count limited to the bitmap size.
    assign n_eff  = ({21'b0, r_bc} > MAXB) ? MAXB[bba_pkg::CNT_W-1:0] : r_bc;
    assign nw_sum = {1'b0, n_eff} + 12'd31;
    assign nwords = nw_sum[11:5];

    assign scan_more = CMP_W'(r_scan_row) < CMP_W'(nwords);
    assign rd_en     = (i_cmd.scan_run && scan_more) || i_cmd.free_read;
    assign rd_row    = i_cmd.free_read ? r_idx[POS_W-1:5] : r_scan_row[ROW_W-1:0];

    // Examine the word read in the previous cycle; rows never written read as clear.
    assign chk_word = r_rd_vld ? r_rd_word : '0;
    assign pos_ext  = RW'({r_chk_row, 5'b0});
    assign n_ext    = RW'(n_eff);
    assign remain   = n_ext - pos_ext;

    always_comb begin
        if (n_ext <= pos_ext) begin
            range_mask = '0;
        end else if (remain >= RW'(bba_pkg::WORD_W)) begin
            range_mask = '1;
        end else begin
            range_mask = (32'h1 << remain[4:0]) - 32'h1;
        end
    end

    assign free_bits = ~chk_word & range_mask;

    always_comb begin
        hit_bit = '0;
        for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_bit = 5'(b);
            end
        end
    end

    assign found    = r_chk_vld && (|free_bits);
    assign out_free = !r_out_vld || i_out_ready;

    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.found     = found;
    assign o_stat.exhausted = !r_chk_vld && !scan_more;
    assign o_stat.out_free  = out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= bba_pkg::RST_BASE;
            r_shift <= bba_pkg::RST_SHIFT;
            r_bc    <= bba_pkg::RST_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bba_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                bba_pkg::CFG_SHIFT: r_shift <= i_cfg_data[bba_pkg::SHIFT_W-1:0];
                bba_pkg::CFG_COUNT: r_bc    <= i_cfg_data[bba_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture and free address arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.operation;
            r_addr <= i_req.free_sector_address;
        end
        if (i_cmd.free_calc) begin
            r_idx   <= (r_addr - r_base) >> r_shift;
            r_below <= r_addr < r_base;
        end
        if (i_cmd.free_read) begin
            r_range <= r_below || (r_idx >= {21'b0, n_eff});
        end
    end

    // Scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= '0;
            r_chk_vld  <= 1'b0;
            r_hit      <= 1'b0;
        end else if (i_cmd.load) begin
            r_scan_row <= '0;
            r_chk_vld  <= 1'b0;
            r_hit      <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_chk_vld <= scan_more;
            if (scan_more) begin
                r_scan_row <= r_scan_row + SC_W'(1);
            end
            if (found && !r_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && scan_more) begin
            r_chk_row <= r_scan_row[ROW_W-1:0];
        end
        if (i_cmd.scan_run && found && !r_hit) begin
            r_blk     <= {r_chk_row, hit_bit};
            r_wr_row  <= r_chk_row;
            r_wr_word <= chk_word | (32'h1 << hit_bit);
        end
    end

    // Bitmap memory, one row read or written per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_row] <= wr_word;
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_row];
            r_rd_vld  <= r_row_vld[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (vld_clear) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_row] <= 1'b1;
        end
    end

    // Commit: state update and result formation
    assign free_word = chk_word & ~(32'h1 << r_idx[4:0]);
    assign blk_wide  = {10'b0, r_blk};

    always_comb begin
        n_cnt     = r_cnt;
        wr_en     = 1'b0;
        wr_row    = r_wr_row;
        wr_word   = r_wr_word;
        vld_clear = 1'b0;
        n_out.status         = bba_pkg::ST_OK;
        n_out.block_number   = '0;
        n_out.sector_address = '0;
        case (r_op)
            bba_pkg::OP_ALLOCATE: begin
                if (r_hit) begin
                    wr_en                = i_cmd.commit;
                    n_cnt                = r_cnt - 11'd1;
                    n_out.block_number   = blk_wide[9:0];
                    n_out.sector_address = r_base + (32'(r_blk) << r_shift);
                end else begin
                    n_out.status = bba_pkg::ST_FULL;
                end
            end
            bba_pkg::OP_FREE: begin
                if (r_range) begin
                    n_out.status = bba_pkg::ST_RANGE;
                end else begin
                    wr_en              = i_cmd.commit;
                    wr_row             = r_idx[POS_W-1:5];
                    wr_word            = free_word;
                    n_out.block_number = r_idx[9:0];
                    if (r_cnt < n_eff) begin
                        n_cnt = r_cnt + 11'd1;
                    end
                end
            end
            bba_pkg::OP_INIT: begin
                vld_clear = i_cmd.commit;
                n_cnt     = n_eff;
            end
            default: ;
        endcase
        n_out.free_count = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_cnt     <= n_cnt;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/block_bitmap_allocator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Block bitmap allocator
// First-fit allocator over a used-block bitmap with a saturating free-block
// counter; supports allocate, free and initialise operations.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  -----------------------------
//  in       input      i_in_valid / o_in_ready  t_alloc_req (operation, addr)
//  out      output     o_out_valid / i_out_ready t_alloc_rsp (status ... count)
//  cfg      input      i_cfg_valid / o_cfg_ready register index and data
//
// An allocate scans only the bitmap rows that cover the blocks in use: it reads
// one 32-bit bitmap row per cycle from the bitmap memory, examines each row
// once its read word is registered and stops at the first row with a clear bit.
// A free subtracts and shifts, reads the row and then writes it back. Reset
// clears the bitmap through per-row valid bits, so the block is ready in the
// cycle after reset. The result register lets the next transaction be
// accepted while a result waits; the commit step stalls only when the result
// register is still occupied.
//
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire bba_pkg::t_alloc_req           i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bba_pkg::t_alloc_rsp                o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bba_pkg::ADDR_W-1:0]    i_cfg_data
);

    bba_pkg::t_dp_cmd  cmd;
    bba_pkg::t_dp_stat stat;

    // Configuration writes are taken at any time; the user must issue them only
    // while idle, as the block has no interlock with the operation in flight.
    assign o_cfg_ready = 1'b1;

    // The controller sequences a single transaction at a time and issues
    // per-phase commands; the datapath reports scan progress and whether
    // the result register is free.
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // The datapath holds the bitmap memory, the counter, the configuration
    // registers and the result register.
    bba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_in_data),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
